// ===== hw/rtl/tgt_pkg.sv =====
package tgt_pkg;

	localparam int ExtTagBits = 32;

	typedef enum logic [2:0] {
		REQ_OPEN   = 3'd0,
		REQ_BEGIN  = 3'd1,
		REQ_CLOSE  = 3'd2,
		REQ_DONE   = 3'd3,
		REQ_FINISH = 3'd4
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BUSY    = 3'd1,
		ST_DISC    = 3'd2,
		ST_STALE   = 3'd3,
		ST_DRAINED = 3'd4
	} status_t;

	typedef struct packed {
		logic [ExtTagBits-1:0] req_tag_in;
		logic [ExtTagBits-1:0] chan_tag_in;
		logic                  remote_drop;
		logic                  direction;
		req_type_t             req_type;
	} item_t;

	typedef struct packed {
		logic                  consistent;
		logic                  cancel_wr;
		logic                  cancel_rd;
		logic [ExtTagBits-1:0] req_tag_out;
		logic [ExtTagBits-1:0] chan_tag_out;
		status_t               status;
	} result_t;

endpackage

// ===== hw/rtl/transfer_generation_tracker.sv =====
// an input beat is registered in the input register, and its result beat in the output register that drives the port
// throughput: one event per cycle while the result port is not stalled, set by the tracker update
// between the input register and the result register
// a stalled result holds in the output register while the input register takes at most
// one more beat and then holds it
// reset is asynchronous: all tracker tags and flags and the valid bits of both pipeline stages clear
module transfer_generation_tracker #(
	parameter int TAG_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // remote_drop, chan_tag_in, req_tag_in, zero pad
	input  logic [3:0]  s_axis_tuser,  // req_type, direction
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // chan_tag_out, req_tag_out, cancel_rd, cancel_wr,
	                                   // consistent, zero pad
	output logic [2:0]  m_axis_tuser   // status
);

	tgt_pkg::item_t   item_in, item_s1;
	tgt_pkg::result_t result_d, result_q;
	logic             valid_s1, out_valid_q, advance;

	assign item_in.req_type    = tgt_pkg::req_type_t'(s_axis_tuser[2:0]);
	assign item_in.direction   = s_axis_tuser[3];
	assign item_in.remote_drop = s_axis_tdata[0];
	assign item_in.chan_tag_in = s_axis_tdata[32:1];
	assign item_in.req_tag_in  = s_axis_tdata[64:33];

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	tgt_core #(
		.TAG_BITS(TAG_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = result_q.status;
	assign m_axis_tdata  = {5'd0, result_q.consistent, result_q.cancel_wr, result_q.cancel_rd,
		result_q.req_tag_out, result_q.chan_tag_out};

endmodule

// ===== hw/rtl/tgt_core.sv =====
module tgt_core #(
	parameter int TAG_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  tgt_pkg::item_t   item,
	output tgt_pkg::result_t result
);

	localparam int CmpBits = (TAG_BITS > tgt_pkg::ExtTagBits) ? TAG_BITS : tgt_pkg::ExtTagBits;

	logic [TAG_BITS-1:0] chan_gen_q, next_req_gen_q, rd_gen_q, wr_gen_q;
	logic                chan_open_q, closing_q, rd_pending_q, wr_pending_q, remote_gone_q;

	logic [TAG_BITS-1:0] chan_gen_d, next_req_gen_d, rd_gen_d, wr_gen_d;
	logic                chan_open_d, closing_d, rd_pending_d, wr_pending_d, remote_gone_d;

	function automatic logic [TAG_BITS-1:0] bump(input logic [TAG_BITS-1:0] v);
		logic [TAG_BITS-1:0] n;
		n = v + 1'b1;
		return (n == '0) ? TAG_BITS'(1) : n;
	endfunction

	logic chan_match, rd_match, wr_match;

	assign chan_match = CmpBits'(item.chan_tag_in) == CmpBits'(chan_gen_q);
	assign rd_match   = CmpBits'(item.req_tag_in) == CmpBits'(rd_gen_q);
	assign wr_match   = CmpBits'(item.req_tag_in) == CmpBits'(wr_gen_q);

	always_comb begin
		chan_gen_d     = chan_gen_q;
		next_req_gen_d = next_req_gen_q;
		rd_gen_d       = rd_gen_q;
		wr_gen_d       = wr_gen_q;
		chan_open_d    = chan_open_q;
		closing_d      = closing_q;
		rd_pending_d   = rd_pending_q;
		wr_pending_d   = wr_pending_q;
		remote_gone_d  = remote_gone_q;
		result         = '0;
		result.status  = tgt_pkg::ST_OK;

		unique case (item.req_type)
			tgt_pkg::REQ_OPEN: begin
				if (chan_open_q || closing_q || rd_pending_q || wr_pending_q) begin
					result.status = tgt_pkg::ST_BUSY;
				end else begin
					chan_gen_d          = bump(chan_gen_q);
					chan_open_d         = 1'b1;
					remote_gone_d       = 1'b0;
					result.chan_tag_out = tgt_pkg::ExtTagBits'(chan_gen_d);
				end
			end
			tgt_pkg::REQ_BEGIN: begin
				if (!chan_open_q || closing_q) begin
					result.status = tgt_pkg::ST_DISC;
				end else if (item.direction ? wr_pending_q : rd_pending_q) begin
					result.status = tgt_pkg::ST_BUSY;
				end else begin
					next_req_gen_d = bump(next_req_gen_q);
					if (item.direction) begin
						wr_pending_d = 1'b1;
						wr_gen_d     = next_req_gen_d;
					end else begin
						rd_pending_d = 1'b1;
						rd_gen_d     = next_req_gen_d;
					end
					result.chan_tag_out = tgt_pkg::ExtTagBits'(chan_gen_q);
					result.req_tag_out  = tgt_pkg::ExtTagBits'(next_req_gen_d);
				end
			end
			tgt_pkg::REQ_CLOSE: begin
				chan_open_d = 1'b0;
				closing_d   = 1'b1;
				if (item.remote_drop) begin
					remote_gone_d = 1'b1;
				end
				result.cancel_rd = rd_pending_q;
				result.cancel_wr = wr_pending_q;
			end
			tgt_pkg::REQ_DONE: begin
				if (!chan_match) begin
					result.status = tgt_pkg::ST_STALE;
				end else if (item.direction) begin
					if (!wr_pending_q || !wr_match) begin
						result.status = tgt_pkg::ST_STALE;
					end else begin
						wr_pending_d = 1'b0;
						wr_gen_d     = '0;
					end
				end else begin
					if (!rd_pending_q || !rd_match) begin
						result.status = tgt_pkg::ST_STALE;
					end else begin
						rd_pending_d = 1'b0;
						rd_gen_d     = '0;
					end
				end
				if (result.status == tgt_pkg::ST_OK && closing_q && !rd_pending_d
						&& !wr_pending_d) begin
					result.status = tgt_pkg::ST_DRAINED;
				end
			end
			tgt_pkg::REQ_FINISH: begin
				if (!closing_q || rd_pending_q || wr_pending_q) begin
					result.status = tgt_pkg::ST_BUSY;
				end else begin
					closing_d = 1'b0;
				end
			end
			default: begin
			end
		endcase

		result.consistent = !(chan_open_d && closing_d)
			&& (rd_pending_d == (rd_gen_d != '0))
			&& (wr_pending_d == (wr_gen_d != '0))
			&& !((rd_pending_d || wr_pending_d) && chan_gen_d == '0)
			&& !(remote_gone_d && chan_open_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_gen_q     <= '0;
			next_req_gen_q <= '0;
			rd_gen_q       <= '0;
			wr_gen_q       <= '0;
			chan_open_q    <= 1'b0;
			closing_q      <= 1'b0;
			rd_pending_q   <= 1'b0;
			wr_pending_q   <= 1'b0;
			remote_gone_q  <= 1'b0;
		end else if (fire) begin
			chan_gen_q     <= chan_gen_d;
			next_req_gen_q <= next_req_gen_d;
			rd_gen_q       <= rd_gen_d;
			wr_gen_q       <= wr_gen_d;
			chan_open_q    <= chan_open_d;
			closing_q      <= closing_d;
			rd_pending_q   <= rd_pending_d;
			wr_pending_q   <= wr_pending_d;
			remote_gone_q  <= remote_gone_d;
		end
	end

endmodule

// ===== hw/rtl/tgt_checker.sv =====
module tgt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	logic       in_beat, out_beat;
	logic [1:0] inflight_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	// every result beat belongs to an input beat taken earlier
	a_no_extra_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 2'd0)
		else $error("result beat without a pending input beat");

	// at most the input stage and the output stage hold work
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more beats in flight than pipeline stages");

	// only a successful open or begin issues tags; a non-ok result carries no tags or cancel flags
	a_tags_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != tgt_pkg::ST_OK |-> m_axis_tdata[65:0] == '0)
		else $error("tags or cancel flags on a non-ok result");

	// stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result beat changed");

endmodule

bind transfer_generation_tracker tgt_checker u_tgt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
